>>> design/uart_drb_pkg.sv
// Shared types and constants for the serial-port dual byte ring block.
package uart_drb_pkg;

    // Request codes carried on req_type
    typedef enum logic [1:0] {
        REQ_RX  = 2'd0,
        REQ_PUT = 2'd1,
        REQ_GET = 2'd2,
        REQ_TXE = 2'd3
    } req_t;

    localparam logic [7:0] CHAR_CR      = 8'h0d;
    localparam logic [7:0] CHAR_LF      = 8'h0a;
    localparam logic [7:0] EMPTY_ANSWER = 8'hff;
    localparam logic [1:0] LEVEL_OFF    = 2'd0;
    localparam logic [1:0] LEVEL_RESET  = 2'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // latch the incoming word
        logic exec;   // update rings, counters and launch memory access
    } drb_cmd_t;

endpackage

>>> design/uart_drb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module uart_drb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/uart_drb_ctrl.sv
// Controller: takes one word at a time, runs it, then holds the result.
module uart_drb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output uart_drb_pkg::drb_cmd_t cmd
);
    import uart_drb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Handshake and commands
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_RESP);
    assign cmd.load  = (state_reg == ST_IDLE) && in_valid;
    assign cmd.exec  = (state_reg == ST_EXEC);

endmodule

>>> design/uart_drb_dpath.sv
// Datapath: ring pointers, byte stores, line counter and interrupt level.
module uart_drb_dpath #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  uart_drb_pkg::drb_cmd_t cmd,
    input  logic [1:0]             req_type,
    input  logic [7:0]             byte_value,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_data,
    output logic [7:0]             got_byte,
    output logic                   got_valid,
    output logic [7:0]             sent_byte,
    output logic                   sent_valid,
    output logic                   put_accepted,
    output logic [1:0]             irq_level_now,
    output logic [7:0]             lines_seen
);
    import uart_drb_pkg::*;

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    req_t             req_reg;
    logic [7:0]       byte_reg;
    logic [RX_AW-1:0] rx_wp_reg, rx_rp_reg;
    logic [TX_AW-1:0] tx_wp_reg, tx_rp_reg;
    logic [7:0]       line_cnt_reg;
    logic [1:0]       irq_level_reg;
    logic [1:0]       irq_setting_reg;
    logic             got_ok_reg, sent_ok_reg, acc_reg;

    logic [RX_AW-1:0] rx_wp_inc, rx_rp_inc;
    logic [TX_AW-1:0] tx_wp_inc, tx_rp_inc;
    logic             rx_full, rx_empty, tx_full, tx_empty;
    logic             do_rx, do_put, do_get, do_txe;
    logic             rx_we, rx_re, tx_we, tx_re;
    logic [7:0]       rx_rdata, tx_rdata;

    // Wrapping pointer increments and ring status
    assign rx_wp_inc = (rx_wp_reg == RX_LAST) ? '0 : rx_wp_reg + 1'b1;
    assign rx_rp_inc = (rx_rp_reg == RX_LAST) ? '0 : rx_rp_reg + 1'b1;
    assign tx_wp_inc = (tx_wp_reg == TX_LAST) ? '0 : tx_wp_reg + 1'b1;
    assign tx_rp_inc = (tx_rp_reg == TX_LAST) ? '0 : tx_rp_reg + 1'b1;
    assign rx_full   = (rx_wp_inc == rx_rp_reg);
    assign rx_empty  = (rx_wp_reg == rx_rp_reg);
    assign tx_full   = (tx_wp_inc == tx_rp_reg);
    assign tx_empty  = (tx_wp_reg == tx_rp_reg);

    // Request decode during the execute cycle
    assign do_rx  = cmd.exec && (req_reg == REQ_RX);
    assign do_put = cmd.exec && (req_reg == REQ_PUT);
    assign do_get = cmd.exec && (req_reg == REQ_GET);
    assign do_txe = cmd.exec && (req_reg == REQ_TXE);

    // Overflowing receive still overwrites the slot at the write pointer
    assign rx_we = do_rx;
    assign rx_re = do_get && !rx_empty;
    assign tx_we = do_put && !tx_full;
    assign tx_re = do_txe && !tx_empty;

    uart_drb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_wp_reg),
        .wdata (byte_reg),
        .re    (rx_re),
        .raddr (rx_rp_reg),
        .rdata (rx_rdata)
    );

    uart_drb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_wp_reg),
        .wdata (byte_reg),
        .re    (tx_re),
        .raddr (tx_rp_reg),
        .rdata (tx_rdata)
    );

    // Input word capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req_t'(req_type);
            byte_reg <= byte_value;
        end
    end

    // Pointers, counter, level and result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wp_reg       <= '0;
            rx_rp_reg       <= '0;
            tx_wp_reg       <= '0;
            tx_rp_reg       <= '0;
            line_cnt_reg    <= '0;
            irq_level_reg   <= LEVEL_OFF;
            irq_setting_reg <= LEVEL_RESET;
            got_ok_reg      <= 1'b0;
            sent_ok_reg     <= 1'b0;
            acc_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                irq_setting_reg <= cfg_data;
            end
            if (do_rx && !rx_full)
            begin
                rx_wp_reg <= rx_wp_inc;
            end
            if (do_rx && (byte_reg == CHAR_CR || byte_reg == CHAR_LF))
            begin
                line_cnt_reg <= line_cnt_reg + 8'd1;
            end
            if (rx_re)
            begin
                rx_rp_reg <= rx_rp_inc;
            end
            if (tx_we)
            begin
                tx_wp_reg     <= tx_wp_inc;
                irq_level_reg <= irq_setting_reg;
            end
            if (tx_re)
            begin
                tx_rp_reg <= tx_rp_inc;
            end
            if (do_txe && tx_empty)
            begin
                irq_level_reg <= LEVEL_OFF;
            end
            if (cmd.exec)
            begin
                got_ok_reg  <= rx_re;
                sent_ok_reg <= tx_re;
                acc_reg     <= tx_we;
            end
        end
    end

    // Result fields; memory read data holds until the next read
    always_comb
    begin
        if (got_ok_reg)
        begin
            got_byte = rx_rdata;
        end
        else if (req_reg == REQ_GET)
        begin
            got_byte = EMPTY_ANSWER;
        end
        else
        begin
            got_byte = 8'd0;
        end
    end

    assign got_valid     = got_ok_reg;
    assign sent_byte     = sent_ok_reg ? tx_rdata : 8'd0;
    assign sent_valid    = sent_ok_reg;
    assign put_accepted  = acc_reg;
    assign irq_level_now = irq_level_reg;
    assign lines_seen    = line_cnt_reg;

endmodule

>>> design/uart_dual_ring_buffer.sv
// Top level of the serial-port receive/transmit byte ring block.
// One request word is handled at a time: a word is accepted when the block is
// idle, executes in the next cycle (pointer update plus at most one ring memory
// access), and its result word is presented in the cycle after that and held
// until taken. A new word is not taken until the last result has been taken;
// the pace is set by the registered read port of the ring memories and the
// one-word-at-a-time controller. Each ring holds at most depth minus one bytes.
// A get on an empty receive ring returns 255; a put to a full transmit ring is
// refused (put_accepted low). The configuration port is always ready and
// should be written only while no word is in flight.
module uart_dual_ring_buffer #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    // request channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic [7:0] byte_value,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] got_byte,
    output logic       got_valid,
    output logic [7:0] sent_byte,
    output logic       sent_valid,
    output logic       put_accepted,
    output logic [1:0] irq_level_now,
    output logic [7:0] lines_seen,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);
    import uart_drb_pkg::*;

    drb_cmd_t cmd;

    assign cfg_ready = 1'b1;

    uart_drb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    uart_drb_dpath #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .req_type      (req_type),
        .byte_value    (byte_value),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .got_byte      (got_byte),
        .got_valid     (got_valid),
        .sent_byte     (sent_byte),
        .sent_valid    (sent_valid),
        .put_accepted  (put_accepted),
        .irq_level_now (irq_level_now),
        .lines_seen    (lines_seen)
    );

`ifndef SYNTHESIS
    // No new word is taken while a result is pending
    a_no_accept_in_resp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("word accepted while result pending");

    // An accepted word yields its result after passing through the execute state
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##2 out_valid)
        else $error("result not presented on time");

    // At most one kind of result flag per word
    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones({got_valid, sent_valid, put_accepted}) <= 1))
        else $error("more than one result flag set");
`endif

endmodule
